@@ hdl/prpz_pkg.sv @@
package prpz_pkg;

	localparam int COORD_W = 16;
	localparam int TRIG_W = 16;
	localparam int DEPTH_W = 24;
	localparam int GLYPH_W = 8;
	localparam int CELL_W = 13;
	localparam int ROT_W = 24;
	localparam int ZC_W = 26;
	localparam int QUO_W = 32;
	localparam logic [GLYPH_W-1:0] BLANK_GLYPH = 8'd32;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = 24'hFFFFFF;

	localparam logic [2:0] REG_SIN_X = 3'd0;
	localparam logic [2:0] REG_COS_X = 3'd1;
	localparam logic [2:0] REG_SIN_Y = 3'd2;
	localparam logic [2:0] REG_COS_Y = 3'd3;
	localparam logic [2:0] REG_SIN_Z = 3'd4;
	localparam logic [2:0] REG_COS_Z = 3'd5;
	localparam logic [2:0] REG_CAM = 3'd6;
	localparam logic [2:0] REG_SCALE = 3'd7;

	// datapath step commands
	localparam logic [3:0] OP_NONE = 4'd0;
	localparam logic [3:0] OP_LOAD = 4'd1;
	localparam logic [3:0] OP_ROTX = 4'd2;
	localparam logic [3:0] OP_ROTY = 4'd3;
	localparam logic [3:0] OP_ROTZ = 4'd4;
	localparam logic [3:0] OP_DEPTH = 4'd5;
	localparam logic [3:0] OP_DIVSTART = 4'd6;
	localparam logic [3:0] OP_DIVSTEP = 4'd7;
	localparam logic [3:0] OP_CHECK = 4'd8;
	localparam logic [3:0] OP_READ = 4'd9;
	localparam logic [3:0] OP_DECIDE = 4'd10;
	localparam logic [3:0] OP_CLEAR = 4'd11;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] div_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic zc_bad;
		logic clear_done;
	} dp_stat_t;

endpackage

@@ hdl/prpz_ctrl.sv @@
module prpz_ctrl
	import prpz_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic in_mode,
	input  logic out_busy,
	input  dp_stat_t stat,
	output dp_cmd_t cmd,
	output logic idle,
	output logic result_push
);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_ROTX = 4'd2;
	localparam logic [3:0] S_ROTY = 4'd3;
	localparam logic [3:0] S_ROTZ = 4'd4;
	localparam logic [3:0] S_DEPTH = 4'd5;
	localparam logic [3:0] S_DIVGO = 4'd6;
	localparam logic [3:0] S_DIV = 4'd7;
	localparam logic [3:0] S_CHECK = 4'd8;
	localparam logic [3:0] S_READ = 4'd9;
	localparam logic [3:0] S_DECIDE = 4'd10;
	localparam logic [3:0] S_PUSH = 4'd11;

	logic [3:0] state_q, state_d;
	logic [1:0] sel_q, sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			sel_q <= 2'd0;
		end else begin
			state_q <= state_d;
			sel_q <= sel_d;
		end
	end

	assign idle = (state_q == S_IDLE) && !out_busy;

	// sequencing: three divisions (recip, column, row) share one divider
	always_comb begin
		state_d = state_q;
		sel_d = sel_q;
		cmd.op = OP_NONE;
		cmd.div_sel = sel_q;
		result_push = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (stat.clear_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_fire) begin
					cmd.op = OP_LOAD;
					state_d = in_mode ? S_READ : S_ROTX;
				end
			end
			S_ROTX: begin cmd.op = OP_ROTX; state_d = S_ROTY; end
			S_ROTY: begin cmd.op = OP_ROTY; state_d = S_ROTZ; end
			S_ROTZ: begin cmd.op = OP_ROTZ; state_d = S_DEPTH; end
			S_DEPTH: begin
				cmd.op = OP_DEPTH;
				sel_d = 2'd0;
				state_d = S_DIVGO;
			end
			S_DIVGO: begin
				if (stat.zc_bad) begin
					state_d = S_PUSH;
				end else begin
					cmd.op = OP_DIVSTART;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.op = OP_DIVSTEP;
				if (stat.div_done) begin
					if (sel_q == 2'd2) begin
						state_d = S_CHECK;
					end else begin
						sel_d = sel_q + 2'd1;
						state_d = S_DIVGO;
					end
				end
			end
			S_CHECK: begin
				cmd.op = OP_CHECK;
				state_d = S_READ;
			end
			S_READ: begin
				cmd.op = OP_READ;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.op = OP_DECIDE;
				state_d = S_PUSH;
			end
			S_PUSH: begin
				result_push = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ hdl/prpz_datapath.sv @@
module prpz_datapath
	import prpz_pkg::*;
#(
	parameter int SCREEN_WIDTH = 160,
	parameter int SCREEN_HEIGHT = 44
) (
	input  logic clk,
	input  logic arst_n,
	input  dp_cmd_t cmd,
	output dp_stat_t stat,
	input  logic in_mode,
	input  logic signed [COORD_W-1:0] in_x,
	input  logic signed [COORD_W-1:0] in_y,
	input  logic signed [COORD_W-1:0] in_z,
	input  logic [GLYPH_W-1:0] in_glyph,
	input  logic [CELL_W-1:0] in_cell,
	input  logic signed [TRIG_W-1:0] sx,
	input  logic signed [TRIG_W-1:0] cx,
	input  logic signed [TRIG_W-1:0] sy,
	input  logic signed [TRIG_W-1:0] cy,
	input  logic signed [TRIG_W-1:0] sz,
	input  logic signed [TRIG_W-1:0] cz,
	input  logic [15:0] cam,
	input  logic [15:0] scale,
	output logic res_written,
	output logic [CELL_W-1:0] res_cell,
	output logic [GLYPH_W-1:0] res_glyph
);

	localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW = $clog2(CELLS);
	localparam int HALF_W = SCREEN_WIDTH / 2;
	localparam int HALF_H = SCREEN_HEIGHT / 2;
	localparam int NUM_W = 64;
	localparam int DEN_W = 34;

	logic [GLYPH_W-1:0] gmem [CELLS];
	logic [DEPTH_W-1:0] dmem [CELLS];

	logic mode_q;
	logic signed [ROT_W-1:0] x_q, y_q, z_q;
	logic [GLYPH_W-1:0] glyph_q;
	logic [CELL_W-1:0] cell_q;
	logic signed [ZC_W-1:0] zc_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] addr_q;
	logic oob_q;
	logic [DEPTH_W-1:0] recip_q;
	logic signed [QUO_W-1:0] col_q, row_q;
	logic [GLYPH_W-1:0] rg_q;
	logic [DEPTH_W-1:0] rd_q;

	// shared long divider state
	logic [NUM_W-1:0] rem_q, quo_q;
	logic [DEN_W-1:0] den_q;
	logic neg_q;
	logic [6:0] cnt_q;

	// rotation products
	logic signed [ROT_W+TRIG_W:0] pa, pb;
	logic signed [ROT_W-1:0] ra, rb;
	logic signed [ROT_W-1:0] m0, m1;
	logic signed [TRIG_W-1:0] t0, t1;

	always_comb begin
		m0 = y_q; m1 = z_q; t0 = cx; t1 = sx;
		pa = '0; pb = '0;
		unique case (cmd.op)
			OP_ROTY: begin
				m0 = x_q; m1 = z_q; t0 = cy; t1 = sy;
				pa = m0 * t0 + m1 * t1;
				pb = m1 * t0 - m0 * t1;
			end
			OP_ROTZ: begin
				m0 = x_q; m1 = y_q; t0 = cz; t1 = sz;
				pa = m0 * t0 - m1 * t1;
				pb = m0 * t1 + m1 * t0;
			end
			default: begin
				pa = m0 * t0 - m1 * t1;
				pb = m0 * t1 + m1 * t0;
			end
		endcase
		ra = ROT_W'(pa >>> 14);
		rb = ROT_W'(pb >>> 14);
	end

	// divider operands: numerator magnitude and sign
	logic signed [NUM_W-1:0] snum;
	logic [NUM_W-1:0] unum;
	logic signed [NUM_W-1:0] den256;
	always_comb begin
		den256 = NUM_W'(zc_q) <<< 8;
		unique case (cmd.div_sel)
			2'd1: snum = NUM_W'(HALF_W) * den256
				+ NUM_W'($signed({1'b0, scale})) * NUM_W'(x_q) * 2;
			2'd2: snum = NUM_W'(HALF_H) * den256
				+ NUM_W'($signed({1'b0, scale})) * NUM_W'(y_q);
			default: snum = NUM_W'(64'sd16777216);
		endcase
		unum = snum[NUM_W-1] ? NUM_W'(-snum) : NUM_W'(snum);
	end

	logic [NUM_W-1:0] trem;
	logic [NUM_W-1:0] remsh;
	assign remsh = {rem_q[NUM_W-2:0], quo_q[NUM_W-1]};
	assign trem = remsh - NUM_W'(den_q);

	logic signed [QUO_W-1:0] qsigned;
	logic [NUM_W-1:0] qfin;
	assign qfin = {quo_q[NUM_W-2:0], ~trem[NUM_W-1]};
	assign qsigned = neg_q ? QUO_W'(-qfin) : QUO_W'(qfin);

	// cell address, only meaningful when the point lands on screen
	logic [AW-1:0] plot_addr;
	assign plot_addr = AW'(row_q) * AW'(SCREEN_WIDTH) + AW'(col_q);

	assign stat.div_done = (cnt_q == 7'd0);
	assign stat.zc_bad = (zc_q <= 0);
	assign stat.clear_done = (clr_q == AW'(CELLS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.op == OP_CLEAR) clr_q <= clr_q + AW'(1);
			if (cmd.op == OP_DIVSTART) cnt_q <= 7'(NUM_W - 1);
			else if (cmd.op == OP_DIVSTEP && cnt_q != 0) cnt_q <= cnt_q - 7'd1;
		end
	end

	// memories, written and read in clocked blocks
	logic mem_we;
	logic [AW-1:0] mem_wa;
	logic [GLYPH_W-1:0] mem_wg;
	logic [DEPTH_W-1:0] mem_wd;
	logic win;
	assign win = !oob_q && (recip_q > rd_q);
	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_q;
		mem_wg = BLANK_GLYPH;
		mem_wd = '0;
		unique case (cmd.op)
			OP_CLEAR: begin mem_we = 1'b1; mem_wa = clr_q; end
			OP_DECIDE: begin
				if (mode_q) begin
					mem_we = !oob_q;
				end else begin
					mem_we = win;
					mem_wg = glyph_q;
					mem_wd = recip_q;
				end
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			gmem[mem_wa] <= mem_wg;
			dmem[mem_wa] <= mem_wd;
		end
		if (cmd.op == OP_READ) begin
			rg_q <= gmem[addr_q];
			rd_q <= dmem[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				mode_q <= in_mode;
				x_q <= ROT_W'(in_x);
				y_q <= ROT_W'(in_y);
				z_q <= ROT_W'(in_z);
				glyph_q <= in_glyph;
				cell_q <= in_cell;
				oob_q <= (32'(in_cell) >= 32'(CELLS));
				addr_q <= AW'(in_cell);
				res_written <= 1'b0;
				res_cell <= '0;
				res_glyph <= '0;
			end
			OP_ROTX: begin y_q <= ra; z_q <= rb; end
			OP_ROTY: begin x_q <= ra; z_q <= rb; end
			OP_ROTZ: begin x_q <= ra; y_q <= rb; end
			OP_DEPTH: zc_q <= ZC_W'(z_q) + ZC_W'({1'b0, cam});
			OP_DIVSTART: begin
				rem_q <= '0;
				quo_q <= unum;
				neg_q <= snum[NUM_W-1];
				den_q <= (cmd.div_sel == 2'd0) ? DEN_W'(zc_q) : DEN_W'(den256);
			end
			OP_DIVSTEP: begin
				rem_q <= trem[NUM_W-1] ? remsh : trem;
				quo_q <= qfin;
				if (cnt_q == 0) begin
					unique case (cmd.div_sel)
						2'd0: recip_q <= (qfin > NUM_W'(DEPTH_MAX)) ? DEPTH_MAX
							: DEPTH_W'(qfin);
						2'd1: col_q <= qsigned;
						default: row_q <= qsigned;
					endcase
				end
			end
			OP_CHECK: begin
				oob_q <= (col_q < 0) || (col_q >= QUO_W'(SCREEN_WIDTH))
					|| (row_q < 0) || (row_q >= QUO_W'(SCREEN_HEIGHT));
				addr_q <= plot_addr;
			end
			OP_DECIDE: begin
				if (mode_q) begin
					res_written <= 1'b0;
					res_cell <= cell_q;
					res_glyph <= oob_q ? BLANK_GLYPH : rg_q;
				end else if (win) begin
					res_written <= 1'b1;
					res_cell <= CELL_W'(addr_q);
					res_glyph <= glyph_q;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ hdl/point_rotate_project_zbuffer_top.sv @@
// a read and clear goes from accept through read and decide to the result; a
// plotted point adds rotation, depth, three 64-step divisions on one shared
// restoring divider and a bounds check; a non-positive depth drops the point
// throughput: one item at a time; the next is taken once the result has left
// reset: asynchronous, active low; afterwards a clearing pass of one cell per
// cycle through all SCREEN_WIDTH*SCREEN_HEIGHT cells precedes the first item
module point_rotate_project_zbuffer_top
	import prpz_pkg::*;
#(
	parameter int SCREEN_WIDTH = 160,
	parameter int SCREEN_HEIGHT = 44
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// mode, point_x, point_y, point_z, glyph, cell_index (lowest first)
	input  logic [71:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// written, cell_out, glyph_out (lowest first)
	output logic [23:0] m_tdata,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [15:0] regs_q [8];
	logic [2:0] ridx;
	assign ridx = paddr[4:2];
	assign pready = 1'b1;
	assign prdata = {16'd0, regs_q[ridx]};

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[REG_SIN_X] <= 16'd0;
			regs_q[REG_COS_X] <= 16'd16384;
			regs_q[REG_SIN_Y] <= 16'd0;
			regs_q[REG_COS_Y] <= 16'd16384;
			regs_q[REG_SIN_Z] <= 16'd0;
			regs_q[REG_COS_Z] <= 16'd16384;
			regs_q[REG_CAM] <= 16'd14080;
			regs_q[REG_SCALE] <= 16'd10240;
		end else if (psel && penable && pwrite) begin
			regs_q[ridx] <= pwdata[15:0];
		end
	end

	dp_cmd_t cmd;
	dp_stat_t stat;
	logic idle, push, fire;
	logic res_written;
	logic [CELL_W-1:0] res_cell;
	logic [GLYPH_W-1:0] res_glyph;
	logic mvalid_q;
	logic [23:0] mdata_q;

	assign s_tready = idle;
	assign fire = s_tvalid && s_tready;

	prpz_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(fire), .in_mode(s_tdata[0]),
		.out_busy(mvalid_q), .stat(stat), .cmd(cmd), .idle(idle),
		.result_push(push)
	);

	prpz_datapath #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_mode(s_tdata[0]), .in_x(s_tdata[16:1]), .in_y(s_tdata[32:17]),
		.in_z(s_tdata[48:33]), .in_glyph(s_tdata[56:49]), .in_cell(s_tdata[69:57]),
		.sx(regs_q[REG_SIN_X]), .cx(regs_q[REG_COS_X]),
		.sy(regs_q[REG_SIN_Y]), .cy(regs_q[REG_COS_Y]),
		.sz(regs_q[REG_SIN_Z]), .cz(regs_q[REG_COS_Z]),
		.cam(regs_q[REG_CAM]), .scale(regs_q[REG_SCALE]),
		.res_written(res_written), .res_cell(res_cell), .res_glyph(res_glyph)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
		end else if (push) begin
			mvalid_q <= 1'b1;
		end else if (m_tready) begin
			mvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mdata_q <= {2'b00, res_glyph, res_cell, res_written};
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata = mdata_q;

endmodule

@@ tb/tb_point_rotate_project_zbuffer_top.sv @@
`timescale 1ns / 1ps

module tb_point_rotate_project_zbuffer_top;
	import prpz_pkg::*;

	localparam int SCR_W = 160;
	localparam int SCR_H = 44;
	localparam int CELLS = SCR_W * SCR_H;
	localparam longint CYCLE_LIMIT = 4000000;
	localparam int SETTLE_CYCLES = 400;
	localparam logic MODE_PLOT = 1'b0;
	localparam logic MODE_READ = 1'b1;

	typedef struct packed {
		logic [12:0] cell_index;
		logic [7:0] glyph;
		logic signed [15:0] pz;
		logic signed [15:0] py;
		logic signed [15:0] px;
		logic mode;
	} point_item_t;

	typedef struct packed {
		logic [7:0] glyph_out;
		logic [12:0] cell_out;
		logic written;
	} cell_result_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	// mode, point_x, point_y, point_z, glyph, cell_index (lowest first)
	logic [71:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	// written, cell_out, glyph_out (lowest first)
	logic [23:0] m_tdata;
	logic psel;
	logic penable;
	logic pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	// shadow of the block's registers and screen
	logic signed [15:0] trig_reg [6];
	logic [15:0] cam_dist;
	logic [15:0] proj_scale;
	logic [7:0] glyph_mirror [CELLS];
	logic [23:0] depth_mirror [CELLS];

	cell_result_t pending_cells [$];
	int fail_count;
	longint cycle_count;

	point_rotate_project_zbuffer_top #(
		.SCREEN_WIDTH(SCR_W),
		.SCREEN_HEIGHT(SCR_H)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12)
			return 0;
		else if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	// receiver stalls
	initial m_tready = 1'b0;
	always @(negedge clk) begin
		int g;
		if (arst_n) begin
			g = rand_gap();
			if (g == 0) begin
				m_tready = 1'b1;
			end else begin
				m_tready = 1'b0;
				repeat (g) @(negedge clk);
				m_tready = 1'b1;
			end
		end
	end

	// compare each result item with the oldest prediction
	always @(posedge clk) begin
		cell_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[21:0];
			if (pending_cells.size() == 0) begin
				$error("unexpected result item %h", m_tdata);
				fail_count++;
			end else begin
				want = pending_cells.pop_front();
				if (got.written !== want.written) begin
					$error("written: expected %0d actual %0d", want.written, got.written);
					fail_count++;
				end
				if (got.cell_out !== want.cell_out) begin
					$error("cell_out: expected %0d actual %0d", want.cell_out, got.cell_out);
					fail_count++;
				end
				if (got.glyph_out !== want.glyph_out) begin
					$error("glyph_out: expected %0d actual %0d", want.glyph_out,
						got.glyph_out);
					fail_count++;
				end
			end
		end
	end

	// rotate, project and depth-test one item against the shadow screen
	function automatic cell_result_t render_point(point_item_t it);
		cell_result_t res;
		longint x, y, z, y1, z1, x2, z2, x3, y3, zc, recip, den, xp, yp, k, cell_idx;
		res = '0;
		if (it.mode == MODE_READ) begin
			res.cell_out = it.cell_index;
			if (it.cell_index < CELLS) begin
				res.glyph_out = glyph_mirror[it.cell_index];
				glyph_mirror[it.cell_index] = BLANK_GLYPH;
				depth_mirror[it.cell_index] = '0;
			end else begin
				res.glyph_out = BLANK_GLYPH;
			end
			return res;
		end
		x = it.px;
		y = it.py;
		z = it.pz;
		y1 = (y * trig_reg[REG_COS_X] - z * trig_reg[REG_SIN_X]) >>> 14;
		z1 = (y * trig_reg[REG_SIN_X] + z * trig_reg[REG_COS_X]) >>> 14;
		x2 = (x * trig_reg[REG_COS_Y] + z1 * trig_reg[REG_SIN_Y]) >>> 14;
		z2 = (z1 * trig_reg[REG_COS_Y] - x * trig_reg[REG_SIN_Y]) >>> 14;
		x3 = (x2 * trig_reg[REG_COS_Z] - y1 * trig_reg[REG_SIN_Z]) >>> 14;
		y3 = (x2 * trig_reg[REG_SIN_Z] + y1 * trig_reg[REG_COS_Z]) >>> 14;
		zc = z2 + longint'(cam_dist);
		if (zc <= 0)
			return res;
		recip = (longint'(1) <<< 24) / zc;
		if (recip > longint'(DEPTH_MAX))
			recip = longint'(DEPTH_MAX);
		k = longint'(proj_scale);
		den = 256 * zc;
		xp = ((SCR_W / 2) * den + 2 * k * x3) / den;
		yp = ((SCR_H / 2) * den + k * y3) / den;
		if (xp < 0 || xp >= SCR_W || yp < 0 || yp >= SCR_H)
			return res;
		cell_idx = xp + yp * SCR_W;
		if (recip > longint'(depth_mirror[cell_idx])) begin
			depth_mirror[cell_idx] = recip[23:0];
			glyph_mirror[cell_idx] = it.glyph;
			res.written = 1'b1;
			res.cell_out = cell_idx[12:0];
			res.glyph_out = it.glyph;
		end
		return res;
	endfunction

	// offer one item after a random gap, predict once it is taken
	task automatic send_item(point_item_t it);
		int g;
		g = rand_gap();
		if (g > 0) begin
			s_tvalid = 1'b0;
			repeat (g) @(negedge clk);
		end
		s_tdata = 72'(it);
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		pending_cells.push_back(render_point(it));
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid = 1'b0;
		while (pending_cells.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [15:0] value);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = {16'b0, value};
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		if (idx == REG_CAM)
			cam_dist = value;
		else if (idx == REG_SCALE)
			proj_scale = value;
		else
			trig_reg[idx] = value;
	endtask

	task automatic set_view(logic signed [15:0] sx, cx, sy, cy, sz, cz,
		logic [15:0] cam, scale);
		reg_write(REG_SIN_X, sx);
		reg_write(REG_COS_X, cx);
		reg_write(REG_SIN_Y, sy);
		reg_write(REG_COS_Y, cy);
		reg_write(REG_SIN_Z, sz);
		reg_write(REG_COS_Z, cz);
		reg_write(REG_CAM, cam);
		reg_write(REG_SCALE, scale);
	endtask

	function automatic logic signed [15:0] rand_trig();
		return 16'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	function automatic point_item_t plot_item(int px, int py, int pz, int g);
		point_item_t it;
		it = '0;
		it.mode = MODE_PLOT;
		it.px = 16'(px);
		it.py = 16'(py);
		it.pz = 16'(pz);
		it.glyph = 8'(g);
		it.cell_index = 13'($urandom);
		return it;
	endfunction

	function automatic point_item_t read_item(int c);
		point_item_t it;
		it = '0;
		it.mode = MODE_READ;
		it.px = 16'($urandom);
		it.py = 16'($urandom);
		it.pz = 16'($urandom);
		it.glyph = 8'($urandom);
		it.cell_index = 13'(c);
		return it;
	endfunction

	// reads at read_pct, else mostly on-screen points, some across all values
	function automatic point_item_t rand_item(int read_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < read_pct)
			return read_item($urandom_range(0, 8191));
		if (r < read_pct + 10)
			return plot_item($urandom, $urandom, $urandom, $urandom);
		return plot_item($signed($urandom_range(0, 16383)) - 8192,
			$signed($urandom_range(0, 8191)) - 4096,
			$signed($urandom_range(0, 16383)) - 8192, $urandom);
	endfunction

	task automatic test_directed();
		send_item(plot_item(0, 0, 0, 8'h41));
		send_item(plot_item(0, 0, 0, 8'h42));
		send_item(plot_item(0, 0, -256, 8'h43));
		send_item(plot_item(32767, 32767, 32767, 8'hFF));
		send_item(plot_item(-32768, -32768, -32768, 8'h00));
		send_item(plot_item(0, 0, -32768, 8'h44));
		send_item(plot_item(-14080, 0, 0, 8'h45));
		send_item(plot_item(-1, -1, 0, 8'h46));
		send_item(plot_item(-256, 0, 0, 8'h47));
		send_item(plot_item(2560, 1536, 0, 8'h48));
		send_item(plot_item(-12000, -3800, 0, 8'h49));
		send_item(plot_item(12000, 3800, 0, 8'h4A));
		send_item(read_item(0));
		send_item(read_item(127));
		send_item(read_item(8191));
		send_item(read_item(SCR_W / 2 + (SCR_H / 2) * SCR_W));
		send_item(plot_item(0, 0, 0, 8'h4B));
		drain_results();
	endtask

	task automatic test_random_plot(int n);
		repeat (n) send_item(rand_item(25));
		drain_results();
	endtask

	// hold the sender until everything is back, then a burst near the centre
	task automatic test_hold_then_burst();
		repeat (20) send_item(rand_item(20));
		drain_results();
		repeat (10) send_item(plot_item($urandom_range(0, 512), 0, 0, $urandom));
		repeat (5) send_item(read_item($urandom_range(0, 127)));
		drain_results();
	endtask

	task automatic test_view_sweep();
		set_view(rand_trig(), rand_trig(), rand_trig(), rand_trig(), rand_trig(),
			rand_trig(), 16'd14080, 16'd10240);
		test_random_plot(80);
		set_view(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
			16'sd16384, 16'd65535, 16'd65535);
		test_random_plot(50);
		set_view(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384,
			-16'sd16384, 16'd0, 16'd0);
		test_random_plot(50);
		set_view(16'sd11585, 16'sd11585, -16'sd11585, 16'sd11585, 16'sd0,
			-16'sd16384, 16'd2560, 16'd65535);
		test_random_plot(50);
		set_view(16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384,
			16'd65535, 16'd20480);
		test_random_plot(50);
		set_view(rand_trig(), rand_trig(), rand_trig(), rand_trig(), rand_trig(),
			rand_trig(), 16'($urandom_range(1000, 30000)), 16'($urandom));
		test_random_plot(80);
		set_view(16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384,
			16'd14080, 16'd10240);
		test_random_plot(60);
	endtask

	initial begin
		fail_count = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		trig_reg[REG_SIN_X] = 16'sd0;
		trig_reg[REG_COS_X] = 16'sd16384;
		trig_reg[REG_SIN_Y] = 16'sd0;
		trig_reg[REG_COS_Y] = 16'sd16384;
		trig_reg[REG_SIN_Z] = 16'sd0;
		trig_reg[REG_COS_Z] = 16'sd16384;
		cam_dist = 16'd14080;
		proj_scale = 16'd10240;
		for (int i = 0; i < CELLS; i++) begin
			glyph_mirror[i] = BLANK_GLYPH;
			depth_mirror[i] = '0;
		end
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_plot(380);
		test_hold_then_burst();
		test_view_sweep();

		drain_results();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
